### rtl/mmgn_pkg.sv
// shared types and constants of the min-max gray normalizer
package mmgn_pkg;

	localparam int ELEV_W   = 16;
	localparam int GRAY_W   = 8;
	localparam int REG_W    = 13;
	localparam int EXP_W    = 2 * REG_W;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_MISMATCH = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic rd_start;
		logic check;
		logic div_step;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/mmgn_ctrl.sv
// controller state machine sequencing clear, load and read requests
module mmgn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        op,
	input  mmgn_pkg::sts_t    sts,
	output mmgn_pkg::cmd_t    cmd
);
	import mmgn_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   accept;

	assign accept = s_tvalid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_READ) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				state_next = sts.skip ? ST_PUSH : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (sts.div_last) state_next = ST_PUSH;
			end
			ST_PUSH: begin
				if (sts.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				cmd.clear    = accept && op == OP_CLEAR;
				cmd.load     = accept && op == OP_LOAD;
				cmd.rd_start = accept && op == OP_READ;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_PUSH: begin
				cmd.push = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/mmgn_datapath.sv
// sample store, min/max tracking, size check, restoring divider and output register
module mmgn_datapath #(
	parameter int MAX_PIXELS  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mmgn_pkg::cmd_t                cmd,
	output mmgn_pkg::sts_t                sts,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mmgn_pkg::REG_W-1:0]    cfg_data,
	input  logic [mmgn_pkg::ELEV_W-1:0]   elevation,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mmgn_pkg::GRAY_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic [1:0]                    m_tuser
);
	import mmgn_pkg::*;

	localparam int CW   = $clog2(MAX_PIXELS + 1);
	localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CMPW = (CW > EXP_W) ? CW : EXP_W;
	localparam int SB   = SAMPLE_BITS;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

	logic [SB-1:0] mem [0:MAX_PIXELS-1];

	logic [REG_W-1:0]  rows_q, cols_q;
	logic [SB-1:0]     min_q, max_q;
	logic [CW-1:0]     count_q, rp_q;
	logic              ovf_q;
	logic [EXP_W-1:0]  expected_q;
	logic [SB-1:0]     rd_data_q;
	logic [1:0]        status_q;
	logic              final_q;
	logic [SB-1:0]     rem_q, span_q;
	logic [GRAY_W-1:0] num_q, quo_q;
	logic [2:0]        step_q;
	logic              m_tvalid_q, m_tlast_q;
	logic [GRAY_W-1:0] m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic [SB+ELEV_W-1:0] elev_ext;
	logic [SB-1:0]        sample;
	logic                 full;
	logic                 mismatch, empty, flat;
	logic [SB-1:0]        off, span, off_c;
	logic [SB+7:0]        num;
	logic [SB:0]          trial;
	logic                 qbit;
	logic [CW-1:0]        rp_inc;

	assign elev_ext = {{SB{1'b0}}, elevation};
	assign sample   = elev_ext[SB-1:0];
	assign full     = (count_q == MAX_CNT);

	assign mismatch = ovf_q || (CMPW'(count_q) != CMPW'(expected_q));
	assign empty    = (rp_q >= count_q);
	assign flat     = (max_q <= min_q) || (rd_data_q < min_q);
	assign off      = rd_data_q - min_q;
	assign span     = max_q - min_q;
	assign off_c    = (off > span) ? span : off;
	assign num      = {off_c, 8'b0} - {8'b0, off_c};
	assign rp_inc   = rp_q + 1'b1;

	assign trial = {rem_q, num_q[GRAY_W-1]};
	assign qbit  = (trial >= {1'b0, span_q});

	assign sts.skip     = mismatch || empty || flat;
	assign sts.div_last = (step_q == 3'd7);
	assign sts.out_free = !m_tvalid_q || m_tready;

	// sample store
	always_ff @(posedge clk) begin
		if (cmd.load && !full) mem[count_q[AW-1:0]] <= sample;
		if (cmd.rd_start) rd_data_q <= mem[rp_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= REG_W'(1);
			cols_q  <= REG_W'(1);
			min_q   <= '1;
			max_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			rp_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS: rows_q <= cfg_data;
					REG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				min_q   <= '1;
				max_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
				rp_q    <= '0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					if (sample < min_q) min_q <= sample;
					if (sample > max_q) max_q <= sample;
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.push && status_q == STAT_OK) begin
				rp_q <= rp_inc;
			end
		end
	end

	// size check and divider
	always_ff @(posedge clk) begin
		if (cmd.rd_start) expected_q <= EXP_W'(rows_q) * EXP_W'(cols_q);
		if (cmd.check) begin
			status_q <= mismatch ? STAT_MISMATCH : (empty ? STAT_EMPTY : STAT_OK);
			final_q  <= !mismatch && !empty && (rp_inc == count_q);
			rem_q    <= num[SB+7:8];
			num_q    <= num[7:0];
			span_q   <= span;
			quo_q    <= '0;
			step_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? SB'(trial - {1'b0, span_q}) : trial[SB-1:0];
			num_q  <= {num_q[GRAY_W-2:0], 1'b0};
			quo_q  <= {quo_q[GRAY_W-2:0], qbit};
			step_q <= step_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			m_tdata_q <= (status_q == STAT_OK) ? quo_q : '0;
			m_tlast_q <= final_q;
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT) else $error("loaded count beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> full) else $error("overflow flag without full store");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= count_q) else $error("read pointer past loaded count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q != STAT_OK |-> m_tdata_q == '0 && !m_tlast_q)
		else $error("error result with nonzero gray or last");
`endif

endmodule

### rtl/min_max_gray_normalizer_core.sv
// top level of the min-max gray normalizer
// Loads unsigned elevation samples into an internal store while tracking the running minimum,
// maximum and sample count, and answers each read request with the next stored sample scaled to
// floor(255*(v-min)/(max-min)), a last flag on tlast and a status on tuser (ok, size mismatch
// against rows times columns, no pixels left). Clear and load requests produce no result. A read
// passes from acceptance to the output register through reading the store and registering rows
// times columns, the size check, eight steps of the restoring divider (one quotient bit a cycle)
// and loading the output register; reads that end in a status code or a flat grid skip the
// divider. A read waits in its last step while the previous result is still held at the output.
// The store needs no clearing pass after reset.
module min_max_gray_normalizer_core #(
	parameter int MAX_PIXELS  = 4096,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [mmgn_pkg::ELEV_W-1:0]   s_tdata,   // elevation
	input  logic [1:0]                    s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [mmgn_pkg::GRAY_W-1:0]   m_tdata,   // gray
	output logic                          m_tlast,
	output logic [1:0]                    m_tuser,   // status
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mmgn_pkg::REG_W-1:0]    cfg_data
);
	import mmgn_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mmgn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	mmgn_datapath #(
		.MAX_PIXELS  (MAX_PIXELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.elevation (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
